/* design/binary_message_framer_crc16_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the framer
// Shared property wrappers, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BINARY_MESSAGE_FRAMER_CRC16_DEFINES_SVH
`define BINARY_MESSAGE_FRAMER_CRC16_DEFINES_SVH

// same-cycle implication
`define BMF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/bmf_pkg.sv */
// ----------------------------------------------------------------------------
// bmf_pkg
// Types and constants for the binary message framer.
// ----------------------------------------------------------------------------
package bmf_pkg;

  localparam logic [7:0] PREAMBLE    = 8'h55;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam int         QDEPTH_DEF  = 4;
  localparam int         STEP_W      = 3;
  localparam logic [STEP_W-1:0] HDR_LAST = 3'd5;  // last header byte index

  typedef enum logic {
    ACT_HEADER  = 1'b0,
    ACT_PAYLOAD = 1'b1
  } action_t;

  typedef struct packed {
    logic        action;
    logic [15:0] msg_type;
    logic [15:0] sender;
    logic [7:0]  payload_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } out_item_t;

  typedef enum logic {
    CMD_HDR  = 1'b0,
    CMD_BYTE = 1'b1
  } cmd_kind_t;

  // queue entry: one header or one payload byte to send
  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] msg_type;
    logic [15:0] sender;
    logic [7:0]  len;
    logic [7:0]  data;
    logic        last;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_BODY,
    BK_CRC_LO,
    BK_CRC_HI
  } bk_state_t;

endpackage

/* design/binary_message_framer_crc16.sv */
// ----------------------------------------------------------------------------
// binary_message_framer_crc16
// Frames header and payload words into a byte stream with a CRC-16 CCITT.
// ----------------------------------------------------------------------------
//
//  port group | dir | payload     | moves one word when
//  -----------+-----+-------------+----------------------
//  in_*       | in  | in_item_t   | in_valid && in_ready
//  out_*      | out | out_item_t  | out_valid && out_ready
//
//  Payload words stream at one per cycle unless the queue or output stalls;
//  each emits one byte, the last one adds the two CRC bytes. A header emits
//  six bytes, eight with the CRC when its length is zero. The byte sequencer
//  sends one byte per cycle while its output slot is free. The command queue
//  lets the input keep accepting while a header drains, until the queue fills.
//  Reset (rst_n low, synchronous) empties the queue and closes any frame.
//  A stalled output holds its byte; the back end waits and the queue fills.
//
module binary_message_framer_crc16
  import bmf_pkg::*;
#(
  parameter int QDEPTH = QDEPTH_DEF  // command queue depth, power of two, >= 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // front -> queue
  logic q_push;
  cmd_t q_push_cmd;
  logic q_full;
  // queue -> back
  logic q_pop;
  logic q_head_valid;
  cmd_t q_head_cmd;

  // front end: frame tracking, drops stray payload words
  bmf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_push_cmd)
  );

  // decouples word acceptance from byte emission
  bmf_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd)
  );

  // back end: byte sequencer, CRC, output register
  bmf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_head_valid),
    .q_cmd     (q_head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* design/bmf_queue.sv */
// ----------------------------------------------------------------------------
// bmf_queue
// Small command FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module bmf_queue
  import bmf_pkg::*;
#(
  parameter int QDEPTH = QDEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int AW = $clog2(QDEPTH);

  cmd_t          mem [QDEPTH];
  logic [AW:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW:0]   rd_ptr_r, rd_ptr_nxt;

  assign head_valid = (wr_ptr_r != rd_ptr_r);
  assign full       = (wr_ptr_r[AW] != rd_ptr_r[AW]) &&
                      (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]);
  assign head_cmd   = mem[rd_ptr_r[AW-1:0]];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r[AW-1:0]] <= push_cmd;
    end
  end

endmodule

/* design/bmf_front.sv */
// ----------------------------------------------------------------------------
// bmf_front
// Accepts input words, tracks the open frame and queues send commands.
// ----------------------------------------------------------------------------
module bmf_front
  import bmf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  logic       frame_open_r, frame_open_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic       accept;
  logic       is_hdr;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_hdr   = (in_data.action == ACT_HEADER);

  always_comb begin
    frame_open_nxt  = frame_open_r;
    bytes_left_nxt  = bytes_left_r;
    q_push          = 1'b0;
    q_cmd.kind      = is_hdr ? CMD_HDR : CMD_BYTE;
    q_cmd.msg_type  = in_data.msg_type;
    q_cmd.sender    = in_data.sender;
    q_cmd.len       = in_data.payload_length;
    q_cmd.data      = in_data.data_byte;
    q_cmd.last      = (bytes_left_r == 8'd1);
    if (accept) begin
      if (is_hdr) begin
        // a new header drops whatever frame was open
        q_push         = 1'b1;
        frame_open_nxt = (in_data.payload_length != 8'd0);
        bytes_left_nxt = in_data.payload_length;
      end else if (frame_open_r) begin
        q_push         = 1'b1;
        bytes_left_nxt = bytes_left_r - 8'd1;
        frame_open_nxt = (bytes_left_r != 8'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      bytes_left_r <= '0;
    end else begin
      frame_open_r <= frame_open_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

endmodule

/* design/bmf_back.sv */
// ----------------------------------------------------------------------------
// bmf_back
// Serializes queued commands into bytes, runs the CRC, owns the output reg.
// ----------------------------------------------------------------------------
`include "binary_message_framer_crc16_defines.svh"

module bmf_back
  import bmf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  bk_state_t         state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic              slot_free;
  logic              emit;
  logic              end_emit;
  logic [7:0]        hdr_byte;

  // MSB-first CCITT fold of one byte
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    unique case (step_r)
      3'd0:    hdr_byte = PREAMBLE;
      3'd1:    hdr_byte = q_cmd.msg_type[7:0];
      3'd2:    hdr_byte = q_cmd.msg_type[15:8];
      3'd3:    hdr_byte = q_cmd.sender[7:0];
      3'd4:    hdr_byte = q_cmd.sender[15:8];
      default: hdr_byte = q_cmd.len;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    crc_nxt      = crc_r;
    q_pop        = 1'b0;
    emit         = 1'b0;
    out_data_nxt = out_data_r;
    unique case (state_r)
      BK_BODY: begin
        if (q_valid && slot_free) begin
          emit = 1'b1;
          out_data_nxt.frame_end = 1'b0;
          if (q_cmd.kind == CMD_HDR) begin
            out_data_nxt.out_byte = hdr_byte;
            // preamble restarts the CRC, later header bytes fold in
            crc_nxt = (step_r == '0) ? 16'h0000 : crc_fold(crc_r, hdr_byte);
            if (step_r == HDR_LAST) begin
              q_pop    = 1'b1;
              step_nxt = '0;
              if (q_cmd.len == 8'd0) begin
                state_nxt = BK_CRC_LO;
              end
            end else begin
              step_nxt = step_r + 1'b1;
            end
          end else begin
            out_data_nxt.out_byte = q_cmd.data;
            crc_nxt = crc_fold(crc_r, q_cmd.data);
            q_pop   = 1'b1;
            if (q_cmd.last) begin
              state_nxt = BK_CRC_LO;
            end
          end
        end
      end
      BK_CRC_LO: begin
        if (slot_free) begin
          emit         = 1'b1;
          out_data_nxt = '{out_byte: crc_r[7:0], frame_end: 1'b0};
          state_nxt    = BK_CRC_HI;
        end
      end
      BK_CRC_HI: begin
        if (slot_free) begin
          emit         = 1'b1;
          out_data_nxt = '{out_byte: crc_r[15:8], frame_end: 1'b1};
          state_nxt    = BK_BODY;
        end
      end
      default: begin
        state_nxt = BK_BODY;
      end
    endcase
    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_BODY;
      step_r      <= '0;
      crc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // CRC high byte leaving the sequencer
  assign end_emit = emit && (state_r == BK_CRC_HI);

  `BMF_ASSERT_NOW(a_step_range, 1'b1, step_r <= HDR_LAST, "header step out of range")
  `BMF_ASSERT_NOW(a_no_pop_in_crc, state_r != BK_BODY, !q_pop, "queue popped during CRC")
  `BMF_ASSERT_NEXT(a_crc_order, state_r == BK_CRC_LO, state_r != BK_BODY, "CRC high missing")
  `BMF_ASSERT_NEXT(a_end_flag, end_emit, out_valid_r && out_data_r.frame_end, "end flag missing")

endmodule

/* bench/tb_binary_message_framer_crc16.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_message_framer_crc16
// Self-checking bench for the message framer. A clocked driver feeds header
// and payload words from a pending queue, a clocked monitor checks every
// stream byte against a local CRC-16 framing model, with random idling on
// both the input and the output side.
// ----------------------------------------------------------------------------
module tb_binary_message_framer_crc16;
  import bmf_pkg::*;

  localparam int LIMIT_CYCLES = 800000;  // hard stop, far beyond a slow pass
  localparam int DRAIN_CYCLES = 60;      // settle time after the last byte

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  binary_message_framer_crc16 uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // words still to be driven, and stream bytes still to be seen
  in_item_t  frame_words[$];
  out_item_t frame_bytes_due[$];

  // local copy of the framer state
  logic [15:0] crc_run;
  logic [7:0]  left_cnt;
  logic        frame_live;

  int unsigned cyc = 0;
  int unsigned errs = 0;
  int unsigned n_frames = 0;
  int unsigned n_empty = 0;
  int unsigned n_abandoned = 0;
  int unsigned n_payload = 0;
  int unsigned n_dropped = 0;
  int unsigned n_checked = 0;

  // --------------------------------------------------------------------------
  // CRC-16 CCITT, msb first, no reflection
  // --------------------------------------------------------------------------
  function automatic logic [15:0] crc16_fold(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  function automatic void expect_byte(logic [7:0] b, logic last);
    out_item_t e;
    e.out_byte  = b;
    e.frame_end = last;
    frame_bytes_due.push_back(e);
  endfunction

  // byte that also goes into the running CRC
  function automatic void expect_crc_byte(logic [7:0] b);
    crc_run = crc16_fold(crc_run, b);
    expect_byte(b, 1'b0);
  endfunction

  function automatic void expect_trailer();
    expect_byte(crc_run[7:0], 1'b0);
    expect_byte(crc_run[15:8], 1'b1);
    frame_live = 1'b0;
    left_cnt   = '0;
  endfunction

  // turns one accepted word into the bytes it must produce
  function automatic void predict_stream(in_item_t w);
    if (w.action == ACT_HEADER) begin
      if (frame_live) n_abandoned++;
      n_frames++;
      crc_run = '0;
      expect_byte(PREAMBLE, 1'b0);   // preamble stays out of the CRC
      expect_crc_byte(w.msg_type[7:0]);
      expect_crc_byte(w.msg_type[15:8]);
      expect_crc_byte(w.sender[7:0]);
      expect_crc_byte(w.sender[15:8]);
      expect_crc_byte(w.payload_length);
      if (w.payload_length == 8'd0) begin
        n_empty++;
        expect_trailer();
      end else begin
        left_cnt   = w.payload_length;
        frame_live = 1'b1;
      end
    end else if (!frame_live) begin
      n_dropped++;                   // stray word, no frame to put it in
    end else begin
      n_payload++;
      expect_crc_byte(w.data_byte);
      left_cnt = left_cnt - 8'd1;
      if (left_cnt == 8'd0) expect_trailer();
    end
  endfunction

  // --------------------------------------------------------------------------
  // idling: windows with no idling at all, otherwise mostly short gaps
  // --------------------------------------------------------------------------
  function automatic bit quiet_window();
    return ((cyc / 700) % 5) == 0;
  endfunction

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // driver
  // --------------------------------------------------------------------------
  int unsigned in_gap = 0;

  always @(posedge clk) begin : drive_words
    logic nv;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_stream(in_data);
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_gap--;
          nv = 1'b0;
        end else if (frame_words.size() != 0) begin
          in_data <= frame_words.pop_front();
          nv = 1'b1;
          if (!quiet_window() && $urandom_range(0, 9) < 4) in_gap = idle_len();
        end else begin
          nv = 1'b0;
        end
      end else begin
        nv = 1'b1;                   // hold until taken
      end
      in_valid <= nv;
    end
  end

  // --------------------------------------------------------------------------
  // monitor and output back-pressure
  // --------------------------------------------------------------------------
  int unsigned out_stall = 0;

  always @(posedge clk) begin : check_bytes
    out_item_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (frame_bytes_due.size() == 0) begin
          errs++;
          $error("unexpected byte %02h (frame_end %0b)", out_data.out_byte,
                 out_data.frame_end);
        end else begin
          e = frame_bytes_due.pop_front();
          n_checked++;
          if (out_data.out_byte !== e.out_byte) begin
            errs++;
            $error("out_byte: expected %02h, got %02h", e.out_byte, out_data.out_byte);
          end
          if (out_data.frame_end !== e.frame_end) begin
            errs++;
            $error("frame_end: expected %0b, got %0b", e.frame_end, out_data.frame_end);
          end
        end
      end
      if (out_stall != 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else if (!quiet_window() && $urandom_range(0, 3) == 0) begin
        out_stall = idle_len() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d bytes outstanding", cyc,
               frame_bytes_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic add_header(logic [15:0] mt, logic [15:0] snd, logic [7:0] len);
    in_item_t w;
    w.action         = ACT_HEADER;
    w.msg_type       = mt;
    w.sender         = snd;
    w.payload_length = len;
    w.data_byte      = $urandom_range(0, 255);   // unused on headers
    frame_words.push_back(w);
  endtask

  task automatic add_payload(logic [7:0] b);
    in_item_t w;
    w.action         = ACT_PAYLOAD;
    w.msg_type       = $urandom_range(0, 65535); // unused on payload words
    w.sender         = $urandom_range(0, 65535);
    w.payload_length = $urandom_range(0, 255);
    w.data_byte      = b;
    frame_words.push_back(w);
  endtask

  task automatic add_random_frame(int unsigned len, int unsigned sent);
    add_header($urandom_range(0, 65535), $urandom_range(0, 65535), len[7:0]);
    for (int unsigned i = 0; i < sent; i++) add_payload($urandom_range(0, 255));
  endtask

  initial begin : stimulus
    int unsigned counted;
    int unsigned gen_left;
    int unsigned len;
    int unsigned k;
    int unsigned r;
    bit big_done;

    crc_run    = '0;
    left_cnt   = '0;
    frame_live = 1'b0;
    counted    = 0;
    gen_left   = 0;
    big_done   = 1'b0;

    // directed: stray word right after reset
    add_payload(8'hAA);
    // empty frames at both field extremes
    add_header(16'h0000, 16'h0000, 8'd0);
    add_header(16'hFFFF, 16'hFFFF, 8'd0);
    // one-byte and two-byte frames, payload extremes
    add_header(16'h00FF, 16'hFF00, 8'd1);
    add_payload(8'h00);
    add_header(16'h1234, 16'h8001, 8'd2);
    add_payload(8'hFF);
    add_payload(8'hA5);
    // abandoned frame: header cuts a length-3 frame after one byte
    add_header(16'hBEEF, 16'h0042, 8'd3);
    add_payload(8'h5A);
    add_header(16'h0001, 16'h7FFF, 8'd1);
    add_payload(8'h80);
    // stray words after a closed frame
    add_payload(8'h01);
    add_payload(8'hFE);
    // header abandoning a frame with no payload seen yet
    add_header(16'hA55A, 16'h5AA5, 8'd255);
    add_header(16'h8000, 16'h0001, 8'd0);

    // random: mostly well-formed frames, some cut short, some noise
    while (counted < 480) begin
      r = $urandom_range(0, 99);
      if (!big_done && counted > 200) begin
        add_random_frame(255, 255);   // one longest frame
        counted += 256;
        gen_left = 0;
        big_done = 1'b1;
      end else if (r < 75) begin
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12) : $urandom_range(13, 64);
        add_random_frame(len, len);
        counted += len + 1;
        gen_left = 0;
      end else if (r < 87) begin
        len = $urandom_range(2, 20);
        k = $urandom_range(1, len - 1);
        add_random_frame(len, k);
        counted += k + 1;
        gen_left = len - k;
      end else begin
        k = $urandom_range(1, 3);
        for (int unsigned i = 0; i < k; i++) begin
          add_payload($urandom_range(0, 255));
          if (gen_left != 0) begin
            gen_left--;
            counted++;
          end
        end
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (frame_words.size() != 0 || in_valid) @(posedge clk);
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d frames (%0d empty, %0d abandoned), %0d payload words, %0d stray dropped",
             n_frames, n_empty, n_abandoned, n_payload, n_dropped);
    $display("checked %0d stream bytes, %0d mismatches", n_checked, errs);
    if (errs == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/bmf_pkg.sv
design/bmf_queue.sv
design/bmf_front.sv
design/bmf_back.sv
design/binary_message_framer_crc16.sv
bench/tb_binary_message_framer_crc16.sv
